[rtl/core/torq_pkg.sv]
// Package for the timestamp-ordered request queue: beat types, codes and sizes.
`default_nettype none

package torq_pkg;

    // Default queue depth
    localparam int MAX_ENTRIES_DEF = 16;

    // Field widths fixed by the interface
    localparam int PROC_W  = 4;
    localparam int STAMP_W = 15;
    localparam int COUNT_W = 5;

    // Request kinds
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Input beat
    typedef struct packed {
        t_req_kind            req_type;
        logic [PROC_W-1:0]    proc_id;
        logic [STAMP_W-1:0]   stamp;
    } t_req;

    // Output beat
    typedef struct packed {
        t_status              status;
        logic                 head_valid;
        logic [PROC_W-1:0]    head_proc;
        logic [STAMP_W-1:0]   head_stamp;
        logic [COUNT_W-1:0]   entry_count;
    } t_rsp;

    // One queue entry as held in the entry memory
    typedef struct packed {
        logic [PROC_W-1:0]    proc_id;
        logic [STAMP_W-1:0]   stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

[rtl/core/torq_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module torq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/torq_engine.sv]
// Sorted-insert and remove sequencer working over the entry memory.
`default_nettype none

module torq_engine #(
    parameter int MAX_ENTRIES = torq_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_stall,
    input  wire torq_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_take,
    output torq_pkg::t_rsp      o_rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_WRNEW = 7'b0001000,
        S_HRD   = 7'b0010000,
        S_HWT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_occ, n_occ;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_found, n_found;
    torq_pkg::t_req      r_req, n_req;
    torq_pkg::t_status   r_status, n_status;
    torq_pkg::t_entry    r_head, n_head;
    logic                r_head_valid, n_head_valid;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    torq_pkg::t_entry        ram_wdata;
    logic [torq_pkg::ENTRY_W-1:0] ram_rdata;
    torq_pkg::t_entry        rd_entry;
    torq_pkg::t_entry        new_entry;
    logic [AW-1:0]           last_idx;
    logic                    new_first;
    logic                    accept;

    // Strict ordering: earlier stamp first, then lower process id
    function automatic logic key_before(
        input torq_pkg::t_entry a,
        input torq_pkg::t_entry b
    );
        logic res;
        if (a.stamp != b.stamp) begin
            res = a.stamp < b.stamp;
        end else begin
            res = a.proc_id < b.proc_id;
        end
        return res;
    endfunction

    torq_ram #(
        .WIDTH(torq_pkg::ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_entry  = torq_pkg::t_entry'(ram_rdata);
    assign new_entry = '{proc_id: r_req.proc_id, stamp: r_req.stamp};
    assign last_idx  = AW'(r_occ - 1'b1);
    assign new_first = key_before(new_entry, rd_entry);
    assign accept    = i_req_valid && !o_req_stall;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);

    // Result beat
    always_comb begin
        o_rsp.status      = r_status;
        o_rsp.head_valid  = r_head_valid;
        o_rsp.head_proc   = r_head.proc_id;
        o_rsp.head_stamp  = r_head.stamp;
        o_rsp.entry_count = torq_pkg::COUNT_W'(r_occ);
    end

    // Sequencer: insert scans from the tail shifting down, remove scans from
    // the head shifting up behind the first match
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_found      = r_found;
        n_req        = r_req;
        n_status     = r_status;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = new_entry;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req    = i_req;
                    n_found  = 1'b0;
                    n_status = torq_pkg::ST_DONE;
                    if (i_req.req_type == torq_pkg::REQ_INSERT) begin
                        if (r_occ >= CW'(MAX_ENTRIES)) begin
                            n_status = torq_pkg::ST_FULL;
                            n_state  = S_HRD;
                        end else if (r_occ == '0) begin
                            // empty queue: new entry goes straight to the head
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = '{proc_id: i_req.proc_id, stamp: i_req.stamp};
                            n_occ     = r_occ + 1'b1;
                            n_state   = S_HRD;
                        end else begin
                            n_idx   = last_idx;
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_status = torq_pkg::ST_NOT_FOUND;
                            n_state  = S_HRD;
                        end else begin
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (r_req.req_type == torq_pkg::REQ_INSERT) begin
                    if (new_first) begin
                        // move this entry one place towards the tail
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_idx + 1'b1);
                        ram_wdata = rd_entry;
                        if (r_idx == '0) begin
                            n_state = S_WRNEW;
                        end else begin
                            n_idx   = r_idx - 1'b1;
                            n_state = S_RD;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_idx + 1'b1);
                        ram_wdata = new_entry;
                        n_occ     = r_occ + 1'b1;
                        n_state   = S_HRD;
                    end
                end else begin
                    if (r_found) begin
                        // close the gap left by the removed entry
                        ram_we    = 1'b1;
                        ram_waddr = r_idx - 1'b1;
                        ram_wdata = rd_entry;
                    end else if (rd_entry.proc_id == r_req.proc_id) begin
                        n_found = 1'b1;
                    end
                    if (r_idx == last_idx) begin
                        if (n_found) begin
                            n_occ = r_occ - 1'b1;
                        end else begin
                            n_status = torq_pkg::ST_NOT_FOUND;
                        end
                        n_state = S_HRD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_WRNEW: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = new_entry;
                n_occ     = r_occ + 1'b1;
                n_state   = S_HRD;
            end
            S_HRD: begin
                if (r_occ == '0) begin
                    n_head       = '0;
                    n_head_valid = 1'b0;
                    n_state      = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_state   = S_HWT;
                end
            end
            S_HWT: begin
                n_head       = rd_entry;
                n_head_valid = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_occ        <= '0;
            r_found      <= 1'b0;
            r_head_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_found      <= n_found;
            r_head_valid <= n_head_valid;
        end
    end

    // Payload state
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_req    <= n_req;
        r_status <= n_status;
        r_head   <= n_head;
    end

    // Occupancy never passes the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(MAX_ENTRIES))
        else $error("occupancy above queue depth");

    // Memory writes only from the states that move or place entries
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE || r_state == S_CHK || r_state == S_WRNEW))
        else $error("entry memory written from wrong state");

    // Reported head agrees with the count
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_head_valid == (r_occ != '0)))
        else $error("head valid disagrees with count");

    // An empty queue reports a zero head
    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_head_valid) |-> (r_head == '0))
        else $error("empty queue head not zero");

    // Count holds steady while a result waits for hand-over
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_occ == $past(r_occ)))
        else $error("count changed outside a request");

endmodule

`default_nettype wire

[rtl/core/timestamp_ordered_request_queue.sv]
// Top level of the timestamp-ordered request queue with its output register.
//
// Keeps up to MAX_ENTRIES (process id, timestamp) requests sorted by stamp,
// ties by lower id, in one entry RAM with a registered read. An insert
// into a queue with entries and room walks from the tail, moving each later
// entry down one place, with a read step and a compare step for each entry
// it compares, the moved ones plus the one it stops at; a remove walks the
// whole queue from the head, a read step and a compare step per queued
// entry, shifting up the entries behind the first match. Both then read the
// head back from the RAM unless the queue is empty. One request is in work
// at a time. The next request can be taken only after the result beat of
// the last one has passed into the output register, and is taken even while
// the beat still waits in the output register. Every request gives one
// result beat with status, head entry and count. There is no clearing pass
// after reset: entries beyond the count are never read.
`default_nettype none

module timestamp_ordered_request_queue #(
    parameter int MAX_ENTRIES = torq_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_stall,
    input  wire torq_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_stall,
    output torq_pkg::t_rsp      o_rsp
);

    logic           eng_valid;
    logic           eng_take;
    torq_pkg::t_rsp eng_rsp;
    logic           r_out_valid, n_out_valid;
    torq_pkg::t_rsp r_out, n_out;

    torq_engine #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(eng_valid),
        .i_rsp_take (eng_take),
        .o_rsp      (eng_rsp)
    );

    // Output register takes a beat whenever it is empty or draining
    assign eng_take = eng_valid && (!r_out_valid || !i_rsp_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (eng_take) begin
            n_out_valid = 1'b1;
            n_out       = eng_rsp;
        end else if (!i_rsp_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // A waiting result beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_rsp_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result beat lost");

    // The engine only hands over into free room
    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_take |-> (!r_out_valid || !i_rsp_stall))
        else $error("result taken without room");

    // No request is taken while the engine holds a result
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_valid |-> o_req_stall)
        else $error("request accepted during result hand-over");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the timestamp-ordered request queue: directed rows, then random traffic.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import torq_pkg::*;

    localparam int DEPTH       = MAX_ENTRIES_DEF;
    localparam int RAND_BEATS  = 1528;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT_RSP = 1200;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 10;
    localparam int REPORT_MAX  = 10;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    t_rsp o_rsp;

    // Shadow copy of the sorted queue
    t_entry      shadow_mem [DEPTH];
    int unsigned shadow_count;

    t_rsp        rsp_due [$];
    t_row        dir_rows [$];
    int          fault_count;
    int          mismatch_count;
    int          rsp_seen;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          cur_typed;
    t_rsp        cur_typed_rsp;

    timestamp_ordered_request_queue #(
        .MAX_ENTRIES (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the shadow queue and return the result it should give
    function automatic t_rsp update_shadow_queue(t_req r);
        t_rsp        res;
        int unsigned pos;
        bit          found;
        pos   = 0;
        found = 1'b0;
        res   = '0;
        if (r.req_type == REQ_INSERT) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // stop at the first entry the new key sorts strictly ahead of
                while (pos < shadow_count &&
                       !(r.stamp < shadow_mem[pos].stamp ||
                         (r.stamp == shadow_mem[pos].stamp &&
                          r.proc_id < shadow_mem[pos].proc_id)))
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_mem[i] = shadow_mem[i-1];
                shadow_mem[pos].proc_id = r.proc_id;
                shadow_mem[pos].stamp   = r.stamp;
                shadow_count++;
                res.status = ST_DONE;
            end
        end else begin
            // earliest entry of that id only
            while (pos < shadow_count && shadow_mem[pos].proc_id != r.proc_id)
                pos++;
            if (pos >= shadow_count) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < shadow_count; i++)
                    shadow_mem[i] = shadow_mem[i+1];
                shadow_count--;
                res.status = ST_DONE;
            end
        end
        if (shadow_count > 0) begin
            res.head_valid = 1'b1;
            res.head_proc  = shadow_mem[0].proc_id;
            res.head_stamp = shadow_mem[0].stamp;
        end
        res.entry_count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void add_row(t_req_kind kind, int unsigned pid, int unsigned stp,
                                    bit typed = 1'b0, t_rsp rsp = '0);
        t_row row;
        row.req.req_type = kind;
        row.req.proc_id  = pid[PROC_W-1:0];
        row.req.stamp    = stp[STAMP_W-1:0];
        row.typed        = typed;
        row.rsp          = rsp;
        dir_rows.push_back(row);
    endfunction

    function automatic t_rsp rsp_of(t_status st, bit hv, int unsigned hp, int unsigned hs,
                                    int unsigned cnt);
        t_rsp r;
        r.status      = st;
        r.head_valid  = hv;
        r.head_proc   = hp[PROC_W-1:0];
        r.head_stamp  = hs[STAMP_W-1:0];
        r.entry_count = cnt[COUNT_W-1:0];
        return r;
    endfunction

    // Offer one beat, hold it until taken, return at the following falling edge
    task automatic send_beat(t_req beat, bit typed, t_rsp typed_rsp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_req_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_valid   = 1'b1;
        i_req         = beat;
        cur_typed     = typed;
        cur_typed_rsp = typed_rsp;
        @(posedge i_clk);
        while (o_req_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_rsp(t_rsp want, t_rsp got);
        if (got.status !== want.status || got.head_valid !== want.head_valid ||
            got.head_proc !== want.head_proc || got.head_stamp !== want.head_stamp ||
            got.entry_count !== want.entry_count) begin
            fault_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch at %0t: exp st=%0d hv=%0d hp=%0d hs=%0d cnt=%0d, got st=%0d hv=%0d hp=%0d hs=%0d cnt=%0d",
                         $realtime, want.status, want.head_valid, want.head_proc,
                         want.head_stamp, want.entry_count, got.status, got.head_valid,
                         got.head_proc, got.head_stamp, got.entry_count);
        end
    endtask

    // Beat monitors: requests feed the shadow queue, results are checked in order
    always @(posedge i_clk) begin : beat_mon
        t_rsp predicted;
        if (i_rst_n && i_req_valid && !o_req_stall) begin
            predicted = update_shadow_queue(i_req);
            rsp_due.push_back(cur_typed ? cur_typed_rsp : predicted);
        end
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            rsp_seen++;
            if (rsp_due.size() == 0) begin
                fault_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result beat at %0t: st=%0d cnt=%0d",
                             $realtime, o_rsp.status, o_rsp.entry_count);
            end else begin
                check_rsp(rsp_due.pop_front(), o_rsp);
            end
        end
    end

    // Receiver: random stall, plus one long hold-off to back the queue up
    initial begin : receiver
        bit hold_done;
        hold_done   = 1'b0;
        i_rsp_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
                hold_done   = 1'b1;
                i_rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles without any beat
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        t_req        beat;
        int unsigned ins_pct;
        int          total;
        int          idx;
        i_rst_n        = 1'b0;
        i_req_valid    = 1'b0;
        i_req          = '0;
        cur_typed      = 1'b0;
        cur_typed_rsp  = '0;
        fault_count    = 0;
        mismatch_count = 0;
        rsp_seen       = 0;
        shadow_count   = 0;
        send_idle_pct  = 32;
        recv_idle_pct  = 51;
        ins_pct        = 50;

        // Directed table
        add_row(REQ_REMOVE, 5, 0, 1'b1, rsp_of(ST_NOT_FOUND, 1'b0, 0, 0, 0));     // empty queue
        add_row(REQ_INSERT, 7, 100, 1'b1, rsp_of(ST_DONE, 1'b1, 7, 100, 1));
        add_row(REQ_INSERT, 15, 32767, 1'b1, rsp_of(ST_DONE, 1'b1, 7, 100, 2));
        add_row(REQ_INSERT, 0, 0, 1'b1, rsp_of(ST_DONE, 1'b1, 0, 0, 3));
        add_row(REQ_INSERT, 3, 100);                                            // tie, lower id
        add_row(REQ_INSERT, 7, 100);                                            // same key again
        add_row(REQ_REMOVE, 7, 0);                                              // first of duplicates
        add_row(REQ_REMOVE, 9, 0, 1'b1, rsp_of(ST_NOT_FOUND, 1'b1, 0, 0, 4));     // absent id
        for (int i = 0; i < 12; i++)
            add_row(REQ_INSERT, (i * 5 + 2) % 16, 50 + i * 1000);
        add_row(REQ_INSERT, 1, 1, 1'b1, rsp_of(ST_FULL, 1'b1, 0, 0, DEPTH));      // full queue
        add_row(REQ_REMOVE, 0, 32767);
        add_row(REQ_REMOVE, 15, 32767);

        total = dir_rows.size() + RAND_BEATS;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        idx = 0;
        foreach (dir_rows[k]) begin
            send_beat(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);
            idx++;
        end

        // Random traffic; insert bias drifts so the queue swings between empty and full
        for (int n = 0; n < RAND_BEATS; n++) begin
            if (idx < total / 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 51;
            end else if (idx < 2 * total / 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % 64 == 0)
                case ($urandom_range(0, 2))
                    0:       ins_pct = 20;
                    1:       ins_pct = 50;
                    default: ins_pct = 85;
                endcase
            beat.req_type = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
            beat.proc_id  = PROC_W'($urandom_range(0, 15));
            // narrow stamps now and then to force ties
            if ($urandom_range(0, 3) == 0)
                beat.stamp = STAMP_W'($urandom_range(0, 7));
            else
                beat.stamp = STAMP_W'($urandom_range(0, 32767));
            if (beat.req_type == REQ_REMOVE && shadow_count > 0 &&
                $urandom_range(0, 99) < 80)
                beat.proc_id = shadow_mem[$urandom_range(0, shadow_count - 1)].proc_id;
            send_beat(beat, 1'b0, '0);
            idx++;
        end
        i_req_valid = 1'b0;

        // Drain
        while (rsp_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        fault_count += rsp_due.size();
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
